// ===== hw/rtl/sosm_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types for the solid-on-solid Metropolis step block.
// No dependencies; imported by the top level.

package sosm_pkg;

	localparam int SOSM_SITES  = 256;
	localparam int SITE_W      = 8;
	localparam int SITE_CODES  = 1 << SITE_W;
	localparam int HEIGHT_W    = 6;
	localparam int THRESH_W    = 17;
	localparam int RAND_W      = 16;
	localparam int HSUM_W      = 14;
	localparam int SQ_W        = 20;
	localparam int ENERGY_W    = 14;
	localparam int INIT_HEIGHT = 20;

	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	localparam logic [HEIGHT_W-1:0] CAP_RST         = HEIGHT_W'(40);
	localparam logic [THRESH_W-1:0] THRESH_RISE_RST = THRESH_W'(8869);
	localparam logic [THRESH_W-1:0] THRESH_FLAT_RST = THRESH_W'(65536);
	localparam logic [THRESH_W-1:0] THRESH_DROP_RST = THRESH_W'(65536);

	// Register index, taken from the word address of the configuration port.
	typedef enum logic [2:0] {
		REG_HEIGHT_CAP       = 3'd0,
		REG_THRESH_UP_RISE   = 3'd1,
		REG_THRESH_UP_FLAT   = 3'd2,
		REG_THRESH_UP_DROP   = 3'd3,
		REG_THRESH_DOWN_RISE = 3'd4,
		REG_THRESH_DOWN_FLAT = 3'd5,
		REG_THRESH_DOWN_DROP = 3'd6
	} sosm_reg_t;

endpackage

// ===== hw/rtl/sosm_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read.
// A read and a write to the same entry in one cycle return the old data.

module sosm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule

// ===== hw/rtl/sos_surface_metropolis_step.sv =====
`timescale 1ns / 1ps
// Solid-on-solid Metropolis step: top level. Depends on sosm_pkg and sosm_ram.
//
// Usage. Each input word (site, step_up, random_value) is one trial move on a
// periodic ring of SITES heights; the site index is reduced modulo SITES.
// Every accepted input word yields exactly one output word (accepted,
// new_height, height_sum, square_sum, surface_energy), all taken after the move.
// Both channels use valid and stall; a word moves on a rising edge with valid
// high and stall low. Configuration goes through the APB port, register i at
// byte address 4*i, and should be written while the block is idle.
//
// Timing. An accepted word is held in the trial stage, where its RAM reads land,
// and then moves to the output register. One word is accepted every cycle while
// the output is not stalled: the site and neighbour heights come from three
// copies of the height RAM, each read once per cycle, and a height written back
// in one cycle is forwarded to the word read in that same cycle.
// When the output register is full and stalled the trial stage holds and
// in_stall rises; nothing is lost.
//
// Reset. After arst_n is released the block sweeps the height RAMs to height
// twenty, one site per cycle through every site, with in_stall held high.

module sos_surface_metropolis_step
	import sosm_pkg::*;
#(
	parameter int SITES = SOSM_SITES
) (
	input  logic                clk,
	input  logic                arst_n,

	input  logic                in_valid,
	output logic                in_stall,
	input  logic [SITE_W-1:0]   site,
	input  logic                step_up,
	input  logic [RAND_W-1:0]   random_value,

	output logic                out_valid,
	input  logic                out_stall,
	output logic                accepted,
	output logic [HEIGHT_W-1:0] new_height,
	output logic [HSUM_W-1:0]   height_sum,
	output logic [SQ_W-1:0]     square_sum,
	output logic [ENERGY_W-1:0] surface_energy,

	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready
);

	localparam int AW = $clog2(SITES);
	localparam logic [AW-1:0] LAST_SITE = AW'(SITES - 1);
	localparam logic [HEIGHT_W-1:0] INIT_H = HEIGHT_W'(INIT_HEIGHT);
	localparam logic [HSUM_W-1:0] HSUM_RST = HSUM_W'(SITES * INIT_HEIGHT);
	localparam logic [SQ_W-1:0] SQ_RST = SQ_W'(SITES * INIT_HEIGHT * INIT_HEIGHT);

	// ---------------- configuration registers ----------------
	logic [HEIGHT_W-1:0] cap_q;
	logic [THRESH_W-1:0] th_up_rise_q, th_up_flat_q, th_up_drop_q;
	logic [THRESH_W-1:0] th_dn_rise_q, th_dn_flat_q, th_dn_drop_q;
	logic                cfg_wr;
	sosm_reg_t           cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite;
	assign cfg_idx = sosm_reg_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q        <= CAP_RST;
			th_up_rise_q <= THRESH_RISE_RST;
			th_up_flat_q <= THRESH_FLAT_RST;
			th_up_drop_q <= THRESH_DROP_RST;
			th_dn_rise_q <= THRESH_RISE_RST;
			th_dn_flat_q <= THRESH_FLAT_RST;
			th_dn_drop_q <= THRESH_DROP_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_HEIGHT_CAP:       cap_q        <= pwdata[HEIGHT_W-1:0];
				REG_THRESH_UP_RISE:   th_up_rise_q <= pwdata[THRESH_W-1:0];
				REG_THRESH_UP_FLAT:   th_up_flat_q <= pwdata[THRESH_W-1:0];
				REG_THRESH_UP_DROP:   th_up_drop_q <= pwdata[THRESH_W-1:0];
				REG_THRESH_DOWN_RISE: th_dn_rise_q <= pwdata[THRESH_W-1:0];
				REG_THRESH_DOWN_FLAT: th_dn_flat_q <= pwdata[THRESH_W-1:0];
				REG_THRESH_DOWN_DROP: th_dn_drop_q <= pwdata[THRESH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_HEIGHT_CAP:       prdata = PDATA_W'(cap_q);
			REG_THRESH_UP_RISE:   prdata = PDATA_W'(th_up_rise_q);
			REG_THRESH_UP_FLAT:   prdata = PDATA_W'(th_up_flat_q);
			REG_THRESH_UP_DROP:   prdata = PDATA_W'(th_up_drop_q);
			REG_THRESH_DOWN_RISE: prdata = PDATA_W'(th_dn_rise_q);
			REG_THRESH_DOWN_FLAT: prdata = PDATA_W'(th_dn_flat_q);
			REG_THRESH_DOWN_DROP: prdata = PDATA_W'(th_dn_drop_q);
			default:              prdata = '0;
		endcase
	end

	// ---------------- site reduction and neighbour addresses ----------------
	// Constant table of site modulo SITES, one entry per input code.
	logic [AW-1:0] site_map [SITE_CODES];

	for (genvar g = 0; g < SITE_CODES; g++) begin : g_site_map
		assign site_map[g] = AW'(g % SITES);
	end

	logic [AW-1:0] x_in, xp_in, xm_in;

	assign x_in  = site_map[site];
	assign xp_in = (x_in == LAST_SITE) ? '0 : x_in + AW'(1);
	assign xm_in = (x_in == '0) ? LAST_SITE : x_in - AW'(1);

	// ---------------- control ----------------
	logic          clearing_q;
	logic [AW-1:0] clr_addr_q;
	logic          s1_valid_q;
	logic          out_valid_q;
	logic          advance;
	logic          accept;

	assign advance  = s1_valid_q & (~out_valid_q | ~out_stall);
	assign in_stall = clearing_q | (s1_valid_q & ~advance);
	assign accept   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == LAST_SITE) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// ---------------- height RAMs ----------------
	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [HEIGHT_W-1:0] ram_wdata;
	logic [HEIGHT_W-1:0] rd_x, rd_p, rd_m;
	logic                wr_move;
	logic [HEIGHT_W-1:0] h_new;
	logic [AW-1:0]       x_s1, xp_s1, xm_s1;

	assign ram_we    = clearing_q | wr_move;
	assign ram_waddr = clearing_q ? clr_addr_q : x_s1;
	assign ram_wdata = clearing_q ? INIT_H : h_new;

	sosm_ram #(.WIDTH(HEIGHT_W), .DEPTH(SITES)) u_ram_x (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.re(accept), .raddr(x_in), .rdata(rd_x)
	);

	sosm_ram #(.WIDTH(HEIGHT_W), .DEPTH(SITES)) u_ram_p (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.re(accept), .raddr(xp_in), .rdata(rd_p)
	);

	sosm_ram #(.WIDTH(HEIGHT_W), .DEPTH(SITES)) u_ram_m (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.re(accept), .raddr(xm_in), .rdata(rd_m)
	);

	// ---------------- trial stage ----------------
	logic              up_s1;
	logic [RAND_W-1:0] rnd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1   <= x_in;
			xp_s1  <= xp_in;
			xm_s1  <= xm_in;
			up_s1  <= step_up;
			rnd_s1 <= random_value;
		end
	end

	// The last write to the RAMs landed at the same edge as this word's reads,
	// which returned the old contents; replaying it is harmless otherwise.
	logic                lw_valid_q;
	logic [AW-1:0]       lw_addr_q;
	logic [HEIGHT_W-1:0] lw_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_valid_q <= 1'b0;
		end else if (ram_we) begin
			lw_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			lw_addr_q <= ram_waddr;
			lw_data_q <= ram_wdata;
		end
	end

	logic [HEIGHT_W-1:0] hx, hp, hm;

	assign hx = (lw_valid_q && lw_addr_q == x_s1)  ? lw_data_q : rd_x;
	assign hp = (lw_valid_q && lw_addr_q == xp_s1) ? lw_data_q : rd_p;
	assign hm = (lw_valid_q && lw_addr_q == xm_s1) ? lw_data_q : rd_m;

	logic [HEIGHT_W:0]   h2w;
	logic                legal;
	logic                worse_m, worse_p;
	logic                rise, drop;
	logic [THRESH_W-1:0] th;
	logic                acc;
	logic [HSUM_W-1:0]   hsum_q, hsum_nx;
	logic [SQ_W-1:0]     sq_q, sq_nx;
	logic [ENERGY_W-1:0] en_q, en_nx;

	// Lowering from zero wraps h2w to its top value, so one compare covers both ends.
	assign h2w   = up_s1 ? {1'b0, hx} + 7'd1 : {1'b0, hx} - 7'd1;
	assign legal = h2w < {1'b0, cap_q};
	assign h_new = h2w[HEIGHT_W-1:0];

	// Each neighbour difference grows by one or shrinks by one.
	assign worse_m = up_s1 ? (hm <= hx) : (hm >= hx);
	assign worse_p = up_s1 ? (hp <= hx) : (hp >= hx);
	assign rise    = worse_m & worse_p;
	assign drop    = ~worse_m & ~worse_p;

	always_comb begin
		if (up_s1) begin
			th = rise ? th_up_rise_q : (drop ? th_up_drop_q : th_up_flat_q);
		end else begin
			th = rise ? th_dn_rise_q : (drop ? th_dn_drop_q : th_dn_flat_q);
		end
	end

	assign acc     = legal & ({1'b0, rnd_s1} < th);
	assign wr_move = advance & acc;

	always_comb begin
		hsum_nx = hsum_q;
		sq_nx   = sq_q;
		en_nx   = en_q;
		if (acc) begin
			if (up_s1) begin
				hsum_nx = hsum_q + HSUM_W'(1);
				sq_nx   = sq_q + SQ_W'({hx, 1'b1});
			end else begin
				hsum_nx = hsum_q - HSUM_W'(1);
				sq_nx   = sq_q - SQ_W'({hx, 1'b0}) + SQ_W'(1);
			end
			if (rise) begin
				en_nx = en_q + ENERGY_W'(2);
			end else if (drop) begin
				en_nx = en_q - ENERGY_W'(2);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsum_q <= HSUM_RST;
			sq_q   <= SQ_RST;
			en_q   <= '0;
		end else if (advance) begin
			hsum_q <= hsum_nx;
			sq_q   <= sq_nx;
			en_q   <= en_nx;
		end
	end

	// ---------------- output register ----------------
	logic                acc_q;
	logic [HEIGHT_W-1:0] nh_q;
	logic [HSUM_W-1:0]   o_hsum_q;
	logic [SQ_W-1:0]     o_sq_q;
	logic [ENERGY_W-1:0] o_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			acc_q    <= acc;
			nh_q     <= acc ? h_new : hx;
			o_hsum_q <= hsum_nx;
			o_sq_q   <= sq_nx;
			o_en_q   <= en_nx;
		end
	end

	assign out_valid      = out_valid_q;
	assign accepted       = acc_q;
	assign new_height     = nh_q;
	assign height_sum     = o_hsum_q;
	assign square_sum     = o_sq_q;
	assign surface_energy = o_en_q;

endmodule
